// ===== rtl/rtgd_pkg.sv =====
// shared types, constants and saturating helpers for the rocket derivative pipeline
package rtgd_pkg;

  localparam int WORD_W = 64;
  localparam int UNS_W  = 63;
  localparam int WIDE_W = 128;

  // fixed latencies of the arithmetic units, in enabled cycles
  localparam int MUL_LAT  = 4;
  localparam int DIV_LAT  = 66;
  localparam int SQRT_LAT = 69;

  localparam logic [WORD_W-1:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] S_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_GRAV  = 3'd0,
    REG_SPINX = 3'd1,
    REG_SPINY = 3'd2,
    REG_SPINZ = 3'd3,
    REG_DRY   = 3'd4,
    REG_FORCE = 3'd5,
    REG_FLOW  = 3'd6,
    REG_BURN  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] pos_z;
    logic signed [63:0] vel_x;
    logic signed [63:0] vel_y;
    logic signed [63:0] vel_z;
    logic [62:0]        sim_time;
    logic [62:0]        craft_mass;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] pos_rate_x;
    logic signed [63:0] pos_rate_y;
    logic signed [63:0] pos_rate_z;
    logic signed [63:0] accel_x;
    logic signed [63:0] accel_y;
    logic signed [63:0] accel_z;
    logic signed [63:0] mass_rate;
    logic signed [63:0] push_x;
    logic signed [63:0] push_y;
    logic signed [63:0] push_z;
    logic               fault;
  } out_item_t;

  function automatic logic [WORD_W-1:0] sat_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S_MIN : S_MAX;
    return s[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] sat_sub(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S_MIN : S_MAX;
    return s[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] sat_neg(logic [WORD_W-1:0] a);
    return (a == S_MIN) ? S_MAX : (~a + 64'd1);
  endfunction

  function automatic logic [WORD_W-1:0] mag(logic [WORD_W-1:0] a);
    return a[WORD_W-1] ? (~a + 64'd1) : a;
  endfunction

endpackage

// ===== rtl/rtgd_in_if.sv =====
// input item channel: valid, ready and the state payload
interface rtgd_in_if;
  logic                valid;
  logic                ready;
  rtgd_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rtgd_out_if.sv =====
// result item channel: valid, ready and the derivative payload
interface rtgd_out_if;
  logic                valid;
  logic                ready;
  rtgd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rtgd_dly.sv =====
// enabled delay line for payload that bypasses the arithmetic units
module rtgd_dly #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];
endmodule

// ===== rtl/rtgd_umul.sv =====
// 64x64 unsigned multiply from four registered 32x32 partial products
module rtgd_umul (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic [127:0]  p_o
);
  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [127:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[31:0] * b_i[31:0];
      lh_q <= a_i[31:0] * b_i[63:32];
      hl_q <= a_i[63:32] * b_i[31:0];
      hh_q <= a_i[63:32] * b_i[63:32];
      p_q  <= {hh_q, 64'd0} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0} + {64'd0, ll_q};
    end
  end

  assign p_o = p_q;
endmodule

// ===== rtl/rtgd_mulq.sv =====
// signed fixed point multiply, truncated toward zero and saturated
module rtgd_mulq #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0]  ma_q, mb_q, res_q;
  logic         neg0_q, neg1_q, neg2_q;
  logic [127:0] prod, sh;

  rtgd_umul u_umul (.clk_i(clk_i), .en_i(en_i), .a_i(ma_q), .b_i(mb_q), .p_o(prod));

  assign sh = prod >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= rtgd_pkg::mag(a_i);
      mb_q   <= rtgd_pkg::mag(b_i);
      neg0_q <= a_i[63] ^ b_i[63];
      neg1_q <= neg0_q;
      neg2_q <= neg1_q;
      if (sh[127:63] != '0) begin
        res_q <= neg2_q ? rtgd_pkg::S_MIN : rtgd_pkg::S_MAX;
      end else begin
        res_q <= neg2_q ? (~sh[63:0] + 64'd1) : sh[63:0];
      end
    end
  end

  assign p_o = res_q;
endmodule

// ===== rtl/rtgd_divq.sv =====
// signed fixed point divide, one restoring quotient bit per stage
module rtgd_divq #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] q_o
);
  localparam int QB = 63;

  logic [63:0]  ma_q, mb_q, res_q;
  logic         neg_p_q;
  logic [127:0] rem_q [QB+1];
  logic [63:0]  d_q   [QB+1];
  logic [QB-1:0] q_q  [QB+1];
  logic         neg_q [QB+1];
  logic         ovf_q [QB+1];
  logic         zero_q[QB+1];
  logic [127:0] num;

  assign num = {64'd0, ma_q} << FRAC_BITS;

  // magnitudes, then the scaled numerator and the overflow check
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q      <= rtgd_pkg::mag(a_i);
      mb_q      <= rtgd_pkg::mag(b_i);
      neg_p_q   <= a_i[63] ^ b_i[63];
      rem_q[0]  <= num;
      d_q[0]    <= mb_q;
      q_q[0]    <= '0;
      neg_q[0]  <= neg_p_q;
      ovf_q[0]  <= num >= ({64'd0, mb_q} << QB);
      zero_q[0] <= mb_q == '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int SH = QB - 1 - k;
    logic [127:0] trial;
    assign trial = {64'd0, d_q[k]} << SH;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[k] >= trial) begin
          rem_q[k+1] <= rem_q[k] - trial;
          q_q[k+1]   <= q_q[k] | (QB'(1) << SH);
        end else begin
          rem_q[k+1] <= rem_q[k];
          q_q[k+1]   <= q_q[k];
        end
        d_q[k+1]    <= d_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[QB]) begin
        res_q <= '0;
      end else if (ovf_q[QB]) begin
        res_q <= neg_q[QB] ? rtgd_pkg::S_MIN : rtgd_pkg::S_MAX;
      end else begin
        res_q <= neg_q[QB] ? (~{1'b0, q_q[QB]} + 64'd1) : {1'b0, q_q[QB]};
      end
    end
  end

  assign q_o = res_q;
endmodule

// ===== rtl/rtgd_sqrt.sv =====
// vector length: exact sum of squares, then one root bit per stage
module rtgd_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  input  logic [63:0] z_i,
  output logic [63:0] len_o
);
  localparam int RB = 64;

  logic [63:0]  mx_q, my_q, mz_q, len_q;
  logic [127:0] sx, sy, sz;
  logic [127:0] rem_q [RB+1];
  logic [63:0]  res_q [RB+1];

  rtgd_umul u_sqx (.clk_i(clk_i), .en_i(en_i), .a_i(mx_q), .b_i(mx_q), .p_o(sx));
  rtgd_umul u_sqy (.clk_i(clk_i), .en_i(en_i), .a_i(my_q), .b_i(my_q), .p_o(sy));
  rtgd_umul u_sqz (.clk_i(clk_i), .en_i(en_i), .a_i(mz_q), .b_i(mz_q), .p_o(sz));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q     <= rtgd_pkg::mag(x_i);
      my_q     <= rtgd_pkg::mag(y_i);
      mz_q     <= rtgd_pkg::mag(z_i);
      rem_q[0] <= sx + sy + sz;
      res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < RB; k++) begin : g_step
    localparam int BI = RB - 1 - k;
    logic [127:0] trial;
    assign trial = ({64'd0, res_q[k]} << (BI + 1)) | (128'd1 << (2 * BI));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[k] >= trial) begin
          rem_q[k+1] <= rem_q[k] - trial;
          res_q[k+1] <= res_q[k] | (64'd1 << BI);
        end else begin
          rem_q[k+1] <= rem_q[k];
          res_q[k+1] <= res_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= res_q[RB][63] ? rtgd_pkg::S_MAX : res_q[RB];
    end
  end

  assign len_o = len_q;
endmodule

// ===== rtl/rocket_thrust_gravity_derivative_top.sv =====
// top level of the rocket thrust and gravity derivative pipeline
// Usage: state items enter on in_i (valid/ready), one derivative item leaves
// on out_o for each of them, in order. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_data_i, one register per cycle, while no item is
// in flight; the registers reset to zero.
// Throughput: one item per cycle while out_o is not stalled. The delay from
// acceptance to the result appearing on out_o is set by the chain of units
// on the gravity and thrust paths: a length unit (one root bit per stage),
// two chained dividers (one quotient bit per stage) and multipliers built
// from four 32x32 partial products.
// Reset clears the valid bits of every stage and the configuration.
// Stall: the whole pipeline moves under one enable; when a finished item
// waits on out_o and the receiver holds ready low, every stage holds and
// in_i.ready drops, so nothing is lost or repeated. Empty stages move on
// whenever the output register is free.
module rocket_thrust_gravity_derivative_top #(
  parameter int          FRAC_BITS    = 32,
  parameter logic [63:0] CUTOFF_SPEED = 64'd4294967
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtgd_in_if.sink     in_i,
  rtgd_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  localparam int L_M = rtgd_pkg::MUL_LAT;
  localparam int L_D = rtgd_pkg::DIV_LAT;
  localparam int L_S = rtgd_pkg::SQRT_LAT;

  // cycle at which each intermediate value sits in a register
  localparam int T_VS   = L_M + 1;          // surface velocity
  localparam int T_VR   = T_VS + 1;         // relative velocity
  localparam int T_R    = L_S;              // radius
  localparam int T_V    = T_VR + L_S;       // relative speed, firing decision
  localparam int T_Q    = T_V + L_D;        // unit relative velocity
  localparam int T_PUSH = T_Q + L_M + 1;    // thrust vector
  localparam int T_G1   = T_R + L_D;        // mu / R
  localparam int T_G    = T_G1 + L_D;       // mu / R / R and r / R
  localparam int T_AG   = T_G + L_M + 1;    // gravity acceleration
  localparam int T_PM   = T_PUSH + L_D;     // thrust acceleration
  localparam int T_OUT  = T_PM + 1;         // output register

  // configuration registers
  logic [62:0] grav_q, dry_q, force_q, flow_q, burn_q;
  logic [63:0] spin_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= '0;
      dry_q   <= '0;
      force_q <= '0;
      flow_q  <= '0;
      burn_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        spin_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (rtgd_pkg::cfg_reg_e'(cfg_idx_i))
        rtgd_pkg::REG_GRAV:  grav_q    <= cfg_data_i[62:0];
        rtgd_pkg::REG_SPINX: spin_q[0] <= cfg_data_i;
        rtgd_pkg::REG_SPINY: spin_q[1] <= cfg_data_i;
        rtgd_pkg::REG_SPINZ: spin_q[2] <= cfg_data_i;
        rtgd_pkg::REG_DRY:   dry_q     <= cfg_data_i[62:0];
        rtgd_pkg::REG_FORCE: force_q   <= cfg_data_i[62:0];
        rtgd_pkg::REG_FLOW:  flow_q    <= cfg_data_i[62:0];
        rtgd_pkg::REG_BURN:  burn_q    <= cfg_data_i[62:0];
        default: ;
      endcase
    end
  end

  // one enable for every stage: move unless a result is waiting
  logic en;
  assign en         = out_o.ready | ~out_o.valid;
  assign in_i.ready = en;

  logic [T_OUT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[T_OUT-2:0], in_i.valid};
    end
  end
  assign out_o.valid = vld_q[T_OUT-1];

  logic [63:0] pos [3];
  logic [63:0] vel [3];
  assign pos[0] = in_i.data.pos_x;
  assign pos[1] = in_i.data.pos_y;
  assign pos[2] = in_i.data.pos_z;
  assign vel[0] = in_i.data.vel_x;
  assign vel[1] = in_i.data.vel_y;
  assign vel[2] = in_i.data.vel_z;

  logic [63:0] vr_q [3];
  logic [63:0] vr_d [3];
  logic [63:0] pos_r [3];
  logic [63:0] r_unit [3];
  logic [63:0] r_unit_g [3];
  logic [63:0] accg_q [3];
  logic [63:0] accg_d [3];
  logic [63:0] push_q [3];
  logic [63:0] push_d [3];
  logic [63:0] acc_t [3];
  logic [63:0] vel_o [3];
  logic [63:0] rad, speed, g1, g, rad_d;
  logic [62:0] mass_p;
  logic        fire_v, fire_p, fire_o;
  logic        pre_fire, pre_fire_v, mz_r, fault_r, fault_o;

  // cross product terms, each rounded on its own, and the relative velocity
  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic [63:0] ta, tb, vel_d;
    logic [63:0] vs_q;
    rtgd_mulq #(.FRAC_BITS(FRAC_BITS)) u_ma (
      .clk_i(clk_i), .en_i(en), .a_i(spin_q[J]), .b_i(pos[K]), .p_o(ta));
    rtgd_mulq #(.FRAC_BITS(FRAC_BITS)) u_mb (
      .clk_i(clk_i), .en_i(en), .a_i(spin_q[K]), .b_i(pos[J]), .p_o(tb));
    rtgd_dly #(.W(64), .N(T_VS)) u_vel (
      .clk_i(clk_i), .en_i(en), .d_i(vel[i]), .q_o(vel_d));
    always_ff @(posedge clk_i) begin
      if (en) begin
        vs_q    <= rtgd_pkg::sat_sub(ta, tb);
        vr_q[i] <= rtgd_pkg::sat_sub(vel_d, vs_q);
      end
    end
    rtgd_dly #(.W(64), .N(L_S)) u_vrd (
      .clk_i(clk_i), .en_i(en), .d_i(vr_q[i]), .q_o(vr_d[i]));
    rtgd_dly #(.W(64), .N(T_R)) u_posd (
      .clk_i(clk_i), .en_i(en), .d_i(pos[i]), .q_o(pos_r[i]));
    rtgd_dly #(.W(64), .N(T_OUT - 1)) u_velo (
      .clk_i(clk_i), .en_i(en), .d_i(vel[i]), .q_o(vel_o[i]));
  end

  rtgd_sqrt u_rad (
    .clk_i(clk_i), .en_i(en), .x_i(pos[0]), .y_i(pos[1]), .z_i(pos[2]), .len_o(rad));
  rtgd_sqrt u_speed (
    .clk_i(clk_i), .en_i(en), .x_i(vr_q[0]), .y_i(vr_q[1]), .z_i(vr_q[2]), .len_o(speed));

  // mass and burn time conditions are known at entry, speed much later
  assign pre_fire = (in_i.data.craft_mass >= dry_q) && (in_i.data.sim_time >= burn_q);
  rtgd_dly #(.W(1), .N(T_V)) u_pre (
    .clk_i(clk_i), .en_i(en), .d_i(pre_fire), .q_o(pre_fire_v));
  assign fire_v = pre_fire_v && (speed > CUTOFF_SPEED);
  // fire_p sits beside the thrust product, in the cycle before push_q
  rtgd_dly #(.W(1), .N(T_PUSH - T_V - 1)) u_firep (
    .clk_i(clk_i), .en_i(en), .d_i(fire_v), .q_o(fire_p));
  rtgd_dly #(.W(1), .N(T_PM - T_PUSH + 1)) u_fireo (
    .clk_i(clk_i), .en_i(en), .d_i(fire_p), .q_o(fire_o));

  rtgd_dly #(.W(63), .N(T_PUSH)) u_mass (
    .clk_i(clk_i), .en_i(en), .d_i(in_i.data.craft_mass), .q_o(mass_p));

  // zero mass or zero radius raises the fault flag
  rtgd_dly #(.W(1), .N(T_R)) u_mz (
    .clk_i(clk_i), .en_i(en), .d_i(in_i.data.craft_mass == '0), .q_o(mz_r));
  assign fault_r = mz_r || (rad == '0);
  rtgd_dly #(.W(1), .N(T_PM - T_R)) u_fault (
    .clk_i(clk_i), .en_i(en), .d_i(fault_r), .q_o(fault_o));

  // gravity magnitude term: (mu / R) / R
  rtgd_divq #(.FRAC_BITS(FRAC_BITS)) u_g1 (
    .clk_i(clk_i), .en_i(en), .a_i({1'b0, grav_q}), .b_i(rad), .q_o(g1));
  rtgd_dly #(.W(64), .N(L_D)) u_radd (
    .clk_i(clk_i), .en_i(en), .d_i(rad), .q_o(rad_d));
  rtgd_divq #(.FRAC_BITS(FRAC_BITS)) u_g2 (
    .clk_i(clk_i), .en_i(en), .a_i(g1), .b_i(rad_d), .q_o(g));

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [63:0] qv, tp, gp, pm;
    // thrust along the negative unit relative velocity
    rtgd_divq #(.FRAC_BITS(FRAC_BITS)) u_qv (
      .clk_i(clk_i), .en_i(en), .a_i(vr_d[i]), .b_i(speed), .q_o(qv));
    rtgd_mulq #(.FRAC_BITS(FRAC_BITS)) u_tp (
      .clk_i(clk_i), .en_i(en), .a_i({1'b0, force_q}), .b_i(qv), .p_o(tp));
    always_ff @(posedge clk_i) begin
      if (en) begin
        push_q[i] <= fire_p ? rtgd_pkg::sat_neg(tp) : '0;
      end
    end
    rtgd_dly #(.W(64), .N(L_D)) u_pushd (
      .clk_i(clk_i), .en_i(en), .d_i(push_q[i]), .q_o(push_d[i]));
    rtgd_divq #(.FRAC_BITS(FRAC_BITS)) u_pm (
      .clk_i(clk_i), .en_i(en), .a_i(push_q[i]), .b_i({1'b0, mass_p}), .q_o(pm));
    assign acc_t[i] = pm;

    // gravity along the negative unit position
    rtgd_divq #(.FRAC_BITS(FRAC_BITS)) u_ru (
      .clk_i(clk_i), .en_i(en), .a_i(pos_r[i]), .b_i(rad), .q_o(r_unit[i]));
    rtgd_dly #(.W(64), .N(L_D)) u_rud (
      .clk_i(clk_i), .en_i(en), .d_i(r_unit[i]), .q_o(r_unit_g[i]));
    rtgd_mulq #(.FRAC_BITS(FRAC_BITS)) u_gp (
      .clk_i(clk_i), .en_i(en), .a_i(g), .b_i(r_unit_g[i]), .p_o(gp));
    always_ff @(posedge clk_i) begin
      if (en) begin
        accg_q[i] <= rtgd_pkg::sat_neg(gp);
      end
    end
    rtgd_dly #(.W(64), .N(T_PM - T_AG)) u_accgd (
      .clk_i(clk_i), .en_i(en), .d_i(accg_q[i]), .q_o(accg_d[i]));
  end

  // output register: combine gravity and thrust, apply the fault rule
  logic [63:0] acc_o [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (fault_o) begin
        acc_o[k] = '0;
      end else if (fire_o) begin
        acc_o[k] = rtgd_pkg::sat_add(accg_d[k], acc_t[k]);
      end else begin
        acc_o[k] = accg_d[k];
      end
    end
  end

  rtgd_pkg::out_item_t res_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.pos_rate_x <= vel_o[0];
      res_q.pos_rate_y <= vel_o[1];
      res_q.pos_rate_z <= vel_o[2];
      res_q.accel_x    <= acc_o[0];
      res_q.accel_y    <= acc_o[1];
      res_q.accel_z    <= acc_o[2];
      res_q.mass_rate  <= fire_o ? (~{1'b0, flow_q} + 64'd1) : '0;
      res_q.push_x     <= push_d[0];
      res_q.push_y     <= push_d[1];
      res_q.push_z     <= push_d[2];
      res_q.fault      <= fault_o;
    end
  end
  assign out_o.data = res_q;

  // a faulted item carries no acceleration
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.fault |->
      (out_o.data.accel_x == '0) && (out_o.data.accel_y == '0) && (out_o.data.accel_z == '0))
    else $error("faulted item has nonzero acceleration");

  // mass only ever decreases
  a_mass_rate_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.mass_rate[63] || (out_o.data.mass_rate == '0)))
    else $error("positive mass rate");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output");
endmodule
